// ===== src/u8dec_pkg.sv =====
// ----------------------------------------------------------------------------
// u8dec_pkg
// Constants and stage record types for the UTF-8 code point decoder.
// ----------------------------------------------------------------------------
package u8dec_pkg;

   localparam int unsigned CP_W    = 21;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned AVAIL_W = 3;
   localparam int unsigned LEN_W   = 3;
   localparam int unsigned TRAIL_W = 6;

   localparam logic [CP_W-1:0]  SURR_LO     = 21'h00d800;
   localparam logic [CP_W-1:0]  SURR_HI     = 21'h00dfff;
   localparam logic [CP_W-1:0]  ERR_CP_RST  = 21'h00fffd;

   localparam logic [BYTE_W-1:0] LEAD2_PAYLOAD = 8'h1f;
   localparam logic [BYTE_W-1:0] LEAD3_PAYLOAD = 8'h0f;
   localparam logic [BYTE_W-1:0] LEAD4_PAYLOAD = 8'h07;
   localparam logic [BYTE_W-1:0] TRAIL_PAYLOAD = 8'h3f;
   localparam logic [BYTE_W-1:0] LEAD2_TAG     = 8'hc0;
   localparam logic [BYTE_W-1:0] LEAD3_TAG     = 8'he0;
   localparam logic [BYTE_W-1:0] LEAD4_TAG     = 8'hf0;
   localparam logic [BYTE_W-1:0] ASCII_TAG_BIT = 8'h80;
   localparam logic [BYTE_W-1:0] TRAIL_LO      = 8'h80;
   localparam logic [BYTE_W-1:0] TRAIL_HI      = 8'hbf;

   // Sequence length codes. LEN_NONE marks a window whose lead cannot start a sequence or that is too short.
   localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
   localparam logic [LEN_W-1:0] LEN_1    = 3'd1;
   localparam logic [LEN_W-1:0] LEN_2    = 3'd2;
   localparam logic [LEN_W-1:0] LEN_3    = 3'd3;
   localparam logic [LEN_W-1:0] LEN_4    = 3'd4;

   localparam logic [AVAIL_W-1:0] AVAIL_2 = 3'd2;
   localparam logic [AVAIL_W-1:0] AVAIL_3 = 3'd3;
   localparam logic [AVAIL_W-1:0] AVAIL_4 = 3'd4;

   // Stage one: lead classified, payload bits split out.
   typedef struct packed {
      logic [LEN_W-1:0]   len;
      logic [6:0]         lead;
      logic [TRAIL_W-1:0] t1;
      logic [TRAIL_W-1:0] t2;
      logic [TRAIL_W-1:0] t3;
      logic [2:0]         trail_ok;
   } s1_type;

   // Stage two: code point assembled, structural errors folded in.
   typedef struct packed {
      logic [LEN_W-1:0] len;
      logic [CP_W-1:0]  cp;
      logic             bad;
   } s2_type;

endpackage

// ===== src/utf8_codepoint_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_codepoint_decoder
// Three-stage pipelined decoder of one UTF-8 sequence window per cycle.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake               Payload
// req       in         start, busy             req_byte0..3, req_avail
// rsp       out        rsp_valid (strobe)      rsp_codepoint, rsp_seq_len,
//                                              rsp_is_error
// csr       in         csr_valid, csr_ready    csr_wdata (error code point)
//
// One item can enter every cycle; each result passes in order through the three
// register stages (classify, assemble, check and select). Busy is never raised
// because the receiver cannot stall and nothing in the pipeline waits on
// anything else.
// Synchronous reset clears the stage valid bits and sets the error code
// point to U+FFFD; payload registers are not reset.
//
module utf8_codepoint_decoder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [u8dec_pkg::BYTE_W-1:0]  req_byte0,
   input  logic [u8dec_pkg::BYTE_W-1:0]  req_byte1,
   input  logic [u8dec_pkg::BYTE_W-1:0]  req_byte2,
   input  logic [u8dec_pkg::BYTE_W-1:0]  req_byte3,
   input  logic [u8dec_pkg::AVAIL_W-1:0] req_avail,
   output logic                          rsp_valid,
   output logic [u8dec_pkg::CP_W-1:0]    rsp_codepoint,
   output logic [u8dec_pkg::LEN_W-1:0]   rsp_seq_len,
   output logic                          rsp_is_error,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [u8dec_pkg::CP_W-1:0]    csr_wdata
);
   import u8dec_pkg::*;

   // The configuration register is always writable; the user must write it only
   // while no item is in flight, as the block itself does not enforce this.
   logic [CP_W-1:0] err_cp_ff, err_cp_in;

   logic   s1_valid_ff, s1_valid_in;
   s1_type s1_ff, s1_in;
   logic   s2_valid_ff, s2_valid_in;
   s2_type s2_ff, s2_in;

   logic             out_valid_ff, out_valid_in;
   logic [CP_W-1:0]  out_cp_ff, out_cp_in;
   logic [LEN_W-1:0] out_len_ff, out_len_in;
   logic             out_err_ff, out_err_in;

   logic accept;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   assign err_cp_in = (csr_valid && csr_ready) ? csr_wdata : err_cp_ff;

   // A trailing byte is good when it lies in 80..BF.
   function automatic logic trail_good(input logic [BYTE_W-1:0] b);
      return (b >= TRAIL_LO) && (b <= TRAIL_HI);
   endfunction

   // Stage one: work out the sequence length from the lead byte and the
   // number of bytes available. Avail values above four compare as four, so
   // the raw field serves directly in the greater-or-equal tests.
   always_comb begin
      s1_valid_in = accept;
      s1_in.len   = LEN_NONE;
      if (req_avail == '0) begin
         s1_in.len = LEN_NONE;
      end else if ((req_byte0 & ASCII_TAG_BIT) == '0) begin
         s1_in.len = LEN_1;
      end else if (((req_byte0 & ~LEAD2_PAYLOAD) == LEAD2_TAG) && (req_avail >= AVAIL_2)) begin
         s1_in.len = LEN_2;
      end else if (((req_byte0 & ~LEAD3_PAYLOAD) == LEAD3_TAG) && (req_avail >= AVAIL_3)) begin
         s1_in.len = LEN_3;
      end else if (((req_byte0 & ~LEAD4_PAYLOAD) == LEAD4_TAG) && (req_avail >= AVAIL_4)) begin
         s1_in.len = LEN_4;
      end
      s1_in.lead     = req_byte0[6:0];
      s1_in.t1       = req_byte1[TRAIL_W-1:0];
      s1_in.t2       = req_byte2[TRAIL_W-1:0];
      s1_in.t3       = req_byte3[TRAIL_W-1:0];
      s1_in.trail_ok = {trail_good(req_byte3), trail_good(req_byte2), trail_good(req_byte1)};
   end

   // Stage two: place the payload bits and check only the trailing bytes
   // that the length actually needs.
   always_comb begin
      logic bad_trail;
      s2_valid_in = s1_valid_ff;
      s2_in.len   = s1_ff.len;
      bad_trail   = 1'b0;
      case (s1_ff.len)
         LEN_1: begin
            s2_in.cp  = {14'd0, s1_ff.lead};
         end
         LEN_2: begin
            s2_in.cp  = {10'd0, s1_ff.lead[4:0], s1_ff.t1};
            bad_trail = !s1_ff.trail_ok[0];
         end
         LEN_3: begin
            s2_in.cp  = {5'd0, s1_ff.lead[3:0], s1_ff.t1, s1_ff.t2};
            bad_trail = !(s1_ff.trail_ok[0] && s1_ff.trail_ok[1]);
         end
         LEN_4: begin
            s2_in.cp  = {s1_ff.lead[2:0], s1_ff.t1, s1_ff.t2, s1_ff.t3};
            bad_trail = !(&s1_ff.trail_ok);
         end
         default: begin
            s2_in.cp  = '0;
         end
      endcase
      s2_in.bad = (s1_ff.len == LEN_NONE) || bad_trail;
   end

   // Stage three: reject surrogates and pick between the decoded value and
   // the configured error code point.
   always_comb begin
      logic bad;
      bad          = s2_ff.bad || ((s2_ff.cp >= SURR_LO) && (s2_ff.cp <= SURR_HI));
      out_valid_in = s2_valid_ff;
      out_err_in   = bad;
      out_cp_in    = bad ? err_cp_ff : s2_ff.cp;
      out_len_in   = bad ? LEN_1 : s2_ff.len;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_cp_ff    <= ERR_CP_RST;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         err_cp_ff    <= err_cp_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff      <= s1_in;
      s2_ff      <= s2_in;
      out_cp_ff  <= out_cp_in;
      out_len_ff <= out_len_in;
      out_err_ff <= out_err_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_codepoint = out_cp_ff;
   assign rsp_seq_len   = out_len_ff;
   assign rsp_is_error  = out_err_ff;

`ifndef SYNTHESIS
   // Every accepted item yields its result through the three register stages.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##3 rsp_valid)
      else $error("result missing three cycles after accept");

   // No result appears without a matching item accepted before it.
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 3))
      else $error("result without a matching item");

   // An item with nothing available must come out as an error.
   a_empty_err: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_avail == '0)) |-> ##3 (rsp_is_error && (rsp_seq_len == LEN_1)))
      else $error("empty window not reported as error");

   // A good result is never a surrogate and an error always consumes one byte.
   a_result_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_error ? ((rsp_seq_len == LEN_1) && (rsp_codepoint == err_cp_ff))
                     : ((rsp_codepoint < SURR_LO) || (rsp_codepoint > SURR_HI))))
      else $error("malformed result");
`endif

endmodule

// ===== tb/tb_utf8_codepoint_decoder.sv =====
// ----------------------------------------------------------------------------
// tb_utf8_codepoint_decoder
// Self-checking testbench for the pipelined UTF-8 code point decoder.
// ----------------------------------------------------------------------------
//
// The bench works in three parts. A table of hand-picked windows covers the
// byte and length extremes, every sequence length, and each way a window can
// be rejected. The expected result is typed into the table where it is obvious
// and left to the predictor elsewhere. After that come several random phases.
// Each phase starts with a new error code point, from the reset value to
// both ends of the 21-bit range. Most random items are well-formed sequences
// with random payload; the rest are broken sequences and plain noise.
// Every accepted item queues one expected result. Each result strobe is
// checked against the oldest entry in that queue.
//
module tb_utf8_codepoint_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   import u8dec_pkg::*;

   // One decoded result, laid out like the result ports.
   typedef struct packed {
      logic [CP_W-1:0]  codepoint;
      logic [LEN_W-1:0] seq_len;
      logic             is_error;
   } decode_type;

   // One input item: the four-byte window and the count of valid bytes.
   typedef struct packed {
      logic [BYTE_W-1:0]  b0;
      logic [BYTE_W-1:0]  b1;
      logic [BYTE_W-1:0]  b2;
      logic [BYTE_W-1:0]  b3;
      logic [AVAIL_W-1:0] avail;
   } window_type;

   // A directed row. When pinned is set, want is the expected result;
   // otherwise the predictor supplies it.
   typedef struct packed {
      window_type win;
      logic       pinned;
      decode_type want;
   } stim_row_type;

   localparam int  N_DIRECTED     = 26;
   localparam int  N_PHASES       = 5;
   localparam int  ITEMS_PER_PHASE = 240;
   localparam int  IDLE_PCT       = 37;
   localparam real RUN_LIMIT_NS   = 2_000_000.0;

   localparam decode_type ERR_AT_RESET = '{ERR_CP_RST, LEN_1, 1'b1};

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [BYTE_W-1:0]    req_byte0;
   logic [BYTE_W-1:0]    req_byte1;
   logic [BYTE_W-1:0]    req_byte2;
   logic [BYTE_W-1:0]    req_byte3;
   logic [AVAIL_W-1:0]   req_avail;
   logic                 rsp_valid;
   logic [CP_W-1:0]      rsp_codepoint;
   logic [LEN_W-1:0]     rsp_seq_len;
   logic                 rsp_is_error;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CP_W-1:0]      csr_wdata;

   // Shadow of the error code point register, updated on each accepted write.
   logic [CP_W-1:0]      err_cp_shadow;
   decode_type           pending_decodes[$];
   int                   error_count;

   // These describe the item currently on the request ports. The monitor
   // reads them at the edge where that item is accepted.
   logic                 item_pinned;
   decode_type           item_want;

   // Set per phase. One phase runs with no idle cycles at all.
   bit                   gaps_on;

   // The table rows are typed right after reset, so error rows carry U+FFFD.
   stim_row_type dir_rows [N_DIRECTED] = '{
      // Plain ASCII at both ends of the range.
      '{'{8'h00, 8'h00, 8'h00, 8'h00, 3'd1}, 1'b1, '{21'h000000, LEN_1, 1'b0}},
      '{'{8'h7f, 8'hff, 8'hff, 8'hff, 3'd1}, 1'b1, '{21'h00007f, LEN_1, 1'b0}},
      // Nothing available.
      '{'{8'h41, 8'h00, 8'h00, 8'h00, 3'd0}, 1'b1, ERR_AT_RESET},
      // An avail count above four is treated as four. The spare bytes are ignored.
      '{'{8'h41, 8'hff, 8'hff, 8'hff, 3'd5}, 1'b1, '{21'h000041, LEN_1, 1'b0}},
      // Lead bytes that cannot start a sequence: continuation bytes and F8-FF.
      '{'{8'h80, 8'h80, 8'h80, 8'h80, 3'd4}, 1'b1, ERR_AT_RESET},
      '{'{8'hff, 8'hbf, 8'hbf, 8'hbf, 3'd4}, 1'b1, ERR_AT_RESET},
      '{'{8'hf8, 8'h88, 8'h80, 8'h80, 3'd4}, 1'b1, ERR_AT_RESET},
      // Two-byte forms, including the overlong C0 80.
      '{'{8'hc2, 8'h80, 8'h00, 8'h00, 3'd2}, 1'b1, '{21'h000080, LEN_2, 1'b0}},
      '{'{8'hdf, 8'hbf, 8'h00, 8'h00, 3'd2}, 1'b1, '{21'h0007ff, LEN_2, 1'b0}},
      '{'{8'hc0, 8'h80, 8'h00, 8'h00, 3'd2}, 1'b1, '{21'h000000, LEN_2, 1'b0}},
      // Short window and bad trailing byte on a two-byte lead.
      '{'{8'hc2, 8'h80, 8'h00, 8'h00, 3'd1}, 1'b1, ERR_AT_RESET},
      '{'{8'hc2, 8'h41, 8'h00, 8'h00, 3'd2}, 1'b1, ERR_AT_RESET},
      // Three-byte forms on both sides of the surrogate block.
      '{'{8'he0, 8'h80, 8'h80, 8'h00, 3'd3}, 1'b1, '{21'h000000, LEN_3, 1'b0}},
      '{'{8'hef, 8'hbf, 8'hbf, 8'h00, 3'd3}, 1'b1, '{21'h00ffff, LEN_3, 1'b0}},
      '{'{8'hed, 8'h9f, 8'hbf, 8'h00, 3'd3}, 1'b1, '{21'h00d7ff, LEN_3, 1'b0}},
      // Surrogates at both ends of the block.
      '{'{8'hed, 8'ha0, 8'h80, 8'h00, 3'd3}, 1'b1, ERR_AT_RESET},
      '{'{8'hed, 8'hbf, 8'hbf, 8'h00, 3'd3}, 1'b1, ERR_AT_RESET},
      // Three-byte lead with a window one byte short, then a bad third byte.
      '{'{8'he1, 8'h80, 8'h80, 8'h00, 3'd2}, 1'b1, ERR_AT_RESET},
      '{'{8'he1, 8'h80, 8'hc0, 8'h00, 3'd3}, 1'b1, ERR_AT_RESET},
      // Four-byte forms, up to the largest value F7 can express.
      '{'{8'hf0, 8'h90, 8'h80, 8'h80, 3'd4}, 1'b1, '{21'h010000, LEN_4, 1'b0}},
      '{'{8'hf4, 8'h8f, 8'hbf, 8'hbf, 3'd6}, 1'b1, '{21'h10ffff, LEN_4, 1'b0}},
      '{'{8'hf7, 8'hbf, 8'hbf, 8'hbf, 3'd7}, 1'b1, '{21'h1fffff, LEN_4, 1'b0}},
      // Four-byte lead with a short window, then a bad last byte.
      '{'{8'hf0, 8'h90, 8'h80, 8'h80, 3'd3}, 1'b1, ERR_AT_RESET},
      '{'{8'hf4, 8'h8f, 8'hbf, 8'h7f, 3'd4}, 1'b1, ERR_AT_RESET},
      // Ordinary text. The predictor gives the expected values.
      '{'{8'he3, 8'h81, 8'h82, 8'hff, 3'd4}, 1'b0, '0},
      '{'{8'hd0, 8'hb1, 8'h00, 8'h00, 3'd3}, 1'b0, '0}
   };

   utf8_codepoint_decoder u_top (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_byte0     (req_byte0),
      .req_byte1     (req_byte1),
      .req_byte2     (req_byte2),
      .req_byte3     (req_byte3),
      .req_avail     (req_avail),
      .rsp_valid     (rsp_valid),
      .rsp_codepoint (rsp_codepoint),
      .rsp_seq_len   (rsp_seq_len),
      .rsp_is_error  (rsp_is_error),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Predicts the decoded result of one window. A length is chosen only when
   // the lead byte's tag matches and the window holds enough bytes. Every
   // other case, and any surrogate or bad trailing byte, falls back to the
   // error code point.
   function automatic decode_type decode_window(input window_type w,
                                                input logic [CP_W-1:0] err_cp);
      logic [BYTE_W-1:0] b [4];
      int unsigned       n;
      logic [LEN_W-1:0]  len;
      logic [CP_W-1:0]   cp;
      logic              bad;
      decode_type        r;
      b[0] = w.b0;
      b[1] = w.b1;
      b[2] = w.b2;
      b[3] = w.b3;
      n    = (w.avail > 3'd4) ? 4 : w.avail;
      len  = LEN_NONE;
      cp   = '0;
      bad  = 1'b0;
      if (n == 0) begin
         bad = 1'b1;
      end else if ((b[0] & ASCII_TAG_BIT) == 8'h00) begin
         len = LEN_1;
         cp  = {13'd0, b[0]};
      end else if ((b[0] & ~LEAD2_PAYLOAD) == LEAD2_TAG && n >= 2) begin
         len = LEN_2;
         cp  = {10'd0, b[0][4:0], b[1][5:0]};
      end else if ((b[0] & ~LEAD3_PAYLOAD) == LEAD3_TAG && n >= 3) begin
         len = LEN_3;
         cp  = {5'd0, b[0][3:0], b[1][5:0], b[2][5:0]};
      end else if ((b[0] & ~LEAD4_PAYLOAD) == LEAD4_TAG && n >= 4) begin
         len = LEN_4;
         cp  = {b[0][2:0], b[1][5:0], b[2][5:0], b[3][5:0]};
      end else begin
         bad = 1'b1;
      end
      if (!bad) begin
         if (cp >= SURR_LO && cp <= SURR_HI) bad = 1'b1;
         for (int i = 1; i < int'(len); i++) begin
            if (b[i] < TRAIL_LO || b[i] > TRAIL_HI) bad = 1'b1;
         end
      end
      if (bad) r = '{err_cp, LEN_1, 1'b1};
      else     r = '{cp, len, 1'b0};
      return r;
   endfunction

   // Builds one random item. Sixty in a hundred are well-formed sequences
   // with random payload and a random amount of slack in avail. Twenty are
   // broken on purpose: the window is cut short, a trailing byte or the lead
   // is damaged, or the bytes are forced into the surrogate block. The last
   // twenty are noise with every bit random.
   function automatic window_type random_window();
      logic [BYTE_W-1:0] b [4];
      logic [1:0]        top;
      int unsigned       kind;
      int unsigned       len;
      int unsigned       idx;
      logic [AVAIL_W-1:0] avail;
      window_type        w;
      kind  = $urandom_range(0, 99);
      for (int i = 0; i < 4; i++) b[i] = BYTE_W'($urandom_range(0, 255));
      avail = AVAIL_W'($urandom_range(0, 7));
      if (kind < 80) begin
         len = $urandom_range(1, 4);
         case (len)
            1: b[0] = {1'b0, b[0][6:0]};
            2: b[0] = {3'b110, b[0][4:0]};
            3: b[0] = {4'b1110, b[0][3:0]};
            default: b[0] = {5'b11110, b[0][2:0]};
         endcase
         for (int i = 1; i < int'(len); i++) b[i] = {2'b10, b[i][5:0]};
         // The surrogate block is a narrow target, so three-byte leads
         // are sometimes steered to ED.
         if (len == 3 && $urandom_range(0, 7) == 0) b[0] = 8'hed;
         avail = AVAIL_W'($urandom_range(len, 7));
         if (kind >= 60) begin
            case ($urandom_range(0, 2))
               0: avail = AVAIL_W'($urandom_range(0, len - 1));
               1: begin
                  if (len > 1) begin
                     idx = $urandom_range(1, len - 1);
                     case ($urandom_range(0, 2))
                        0:       top = 2'b00;
                        1:       top = 2'b01;
                        default: top = 2'b11;
                     endcase
                     b[idx] = {top, b[idx][5:0]};
                  end else begin
                     // A stray continuation byte in the lead position.
                     b[0] = {2'b10, b[0][5:0]};
                  end
               end
               default: begin
                  b[0]  = 8'hed;
                  b[1]  = {3'b101, b[1][4:0]};
                  b[2]  = {2'b10, b[2][5:0]};
                  avail = AVAIL_W'($urandom_range(3, 7));
               end
            endcase
         end
      end
      w = '{b[0], b[1], b[2], b[3], avail};
      return w;
   endfunction

   task automatic note_mismatch(input string what, input decode_type want,
                                input decode_type got);
      error_count++;
      if (error_count <= 10) begin
         $display("[%0t] %s: expected cp=%h len=%0d err=%b, got cp=%h len=%0d err=%b",
                  $realtime, what, want.codepoint, want.seq_len, want.is_error,
                  got.codepoint, got.seq_len, got.is_error);
      end
   endtask

   // Monitor and scoreboard share one process clocked on the rising edge.
   // Expectations are queued, the register shadow is updated, and results are
   // checked in a fixed order. All of it sees values from before the edge.
   always @(posedge clock) begin
      decode_type got;
      decode_type want;
      if (!reset) begin
         if (start && !busy) begin
            if (item_pinned) begin
               pending_decodes.push_back(item_want);
            end else begin
               pending_decodes.push_back(decode_window(
                  '{req_byte0, req_byte1, req_byte2, req_byte3, req_avail},
                  err_cp_shadow));
            end
         end
         if (csr_valid && csr_ready) err_cp_shadow = csr_wdata;
         if (rsp_valid) begin
            got = '{rsp_codepoint, rsp_seq_len, rsp_is_error};
            if (pending_decodes.size() == 0) begin
               note_mismatch("result with no item outstanding", '0, got);
            end else begin
               want = pending_decodes.pop_front();
               if (got.codepoint !== want.codepoint || got.seq_len !== want.seq_len ||
                   got.is_error !== want.is_error) begin
                  note_mismatch("result mismatch", want, got);
               end
            end
         end
      end
   end

   // Presents one item at a falling edge and holds it until an edge where
   // busy is low. When the task returns, the bench is at the next falling
   // edge and start is still high, so a following item can go back to back
   // without start dropping.
   task automatic send_window(input window_type w, input logic pinned,
                              input decode_type want);
      if (gaps_on) begin
         while ($urandom_range(0, 99) < IDLE_PCT) begin
            start = 1'b0;
            @(negedge clock);
         end
      end
      req_byte0   = w.b0;
      req_byte1   = w.b1;
      req_byte2   = w.b2;
      req_byte3   = w.b3;
      req_avail   = w.avail;
      item_pinned = pinned;
      item_want   = want;
      start       = 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // Stops sending and waits until every queued result has come back.
   // Each item yields exactly one result, so an empty queue means the
   // pipeline is empty.
   task automatic drain_pipeline();
      start = 1'b0;
      while (pending_decodes.size() != 0) @(negedge clock);
   endtask

   task automatic write_error_cp(input logic [CP_W-1:0] value);
      while ($urandom_range(0, 99) < IDLE_PCT) @(negedge clock);
      csr_wdata = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   initial begin
      logic [CP_W-1:0] phase_cp [N_PHASES];
      int              wait_cycles;
      reset         = 1'b1;
      start         = 1'b0;
      req_byte0     = '0;
      req_byte1     = '0;
      req_byte2     = '0;
      req_byte3     = '0;
      req_avail     = '0;
      csr_valid     = 1'b0;
      csr_wdata     = '0;
      item_pinned   = 1'b0;
      item_want     = '0;
      gaps_on       = 1'b1;
      err_cp_shadow = ERR_CP_RST;
      error_count   = 0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table, run while the register still holds its reset value.
      foreach (dir_rows[i]) begin
         send_window(dir_rows[i].win, dir_rows[i].pinned, dir_rows[i].want);
      end
      drain_pipeline();

      // Each random phase uses its own error code point: both extremes,
      // a random value, the top of Unicode, and finally back to U+FFFD.
      phase_cp[0] = '0;
      phase_cp[1] = '1;
      phase_cp[2] = CP_W'($urandom_range(0, 21'h1fffff));
      phase_cp[3] = 21'h10ffff;
      phase_cp[4] = ERR_CP_RST;
      for (int p = 0; p < N_PHASES; p++) begin
         write_error_cp(phase_cp[p]);
         // The middle phase sends back to back the whole way through.
         gaps_on = (p != 2);
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            send_window(random_window(), 1'b0, '0);
         end
         drain_pipeline();
      end

      // The queue is already empty here. Waiting on after that catches any extra
      // result strobes. An expectation still left counts as a failure.
      wait_cycles = 0;
      while (pending_decodes.size() != 0 && wait_cycles < 200) begin
         @(negedge clock);
         wait_cycles++;
      end
      repeat (8) @(negedge clock);
      if (pending_decodes.size() != 0) begin
         error_count += pending_decodes.size();
         $display("%0d expected results never arrived", pending_decodes.size());
      end

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog. A correct run finishes in a small fraction of this time.
   initial begin
      #(RUN_LIMIT_NS);
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/u8dec_pkg.sv
src/utf8_codepoint_decoder.sv
tb/tb_utf8_codepoint_decoder.sv
